/* rtl/core/gba_pkg.sv */
// Shared types and constants for the group-by aggregator.
// No dependencies; used by every module of the block but gba_ram.
`default_nettype none
package gba_pkg;

	// request codes on the input channel
	localparam logic [1:0] REQ_ACC   = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// classified operations between front and back
	localparam logic [1:0] OP_ACC   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_MISS  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam int KEY_W    = 10;
	localparam int VAL_W    = 32;
	localparam int CNT_W    = 32;
	localparam int SUM_W    = 64;
	localparam int AVG_W    = 48;
	localparam int FRAC_W   = 16;
	localparam int DVD_W    = SUM_W + FRAC_W;
	localparam int DIV_CW   = $clog2(DVD_W + 1);
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic             vld;
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] sum;
		logic [VAL_W-1:0] mn;
		logic [VAL_W-1:0] mx;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
		logic [VAL_W-1:0] mn;
		logic [VAL_W-1:0] mx;
		logic [AVG_W-1:0] avg;
	} result_t;

	typedef struct packed {
		logic clearing;
		logic s1_v;
		logic div_busy;
	} back_stat_t;

endpackage
`default_nettype wire

/* rtl/core/gba_if.sv */
// Channel interfaces of the group-by aggregator: request and response.
// Depends on gba_pkg for field widths.
`default_nettype none
interface gba_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic [gba_pkg::KEY_W-1:0] grp_key;
	logic [gba_pkg::VAL_W-1:0] value;
	modport source (output valid, req_type, grp_key, value, input ready);
	modport sink (input valid, req_type, grp_key, value, output ready);
endinterface

interface gba_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [gba_pkg::CNT_W-1:0] group_count;
	logic [gba_pkg::SUM_W-1:0] group_sum;
	logic [gba_pkg::VAL_W-1:0] group_min;
	logic [gba_pkg::VAL_W-1:0] group_max;
	logic [gba_pkg::AVG_W-1:0] group_avg;
	modport source (output valid, found, group_count, group_sum, group_min, group_max,
		group_avg, input ready);
	modport sink (input valid, found, group_count, group_sum, group_min, group_max,
		group_avg, output ready);
endinterface
`default_nettype wire

/* rtl/core/group_by_aggregator.sv */
// Group-by aggregator: per-group count, sum, min, max and average.
// Depends on gba_pkg, gba_if, gba_front, gba_back (gba_ram, gba_div).
//
// Channels: req carries beats of (req_type, grp_key, value); type 0
// accumulates value into a group, 1 reads a group, 2 clears every group,
// 3 is dropped. rsp returns one beat per read: found, count, sum, min,
// max and the Q32.16 average.
// Throughput: accumulate beats run at one per cycle, including the same
// key in consecutive beats (the table write is forwarded to the next read),
// while no clear sweep or read waiting for the divider holds issue. A read
// of a present group runs the serial divider over 80 quotient bits; later
// reads wait for it. An absent read skips the division and an out-of-range
// read answers from s1. Accumulate beats write the table from stage s1.
// Reset and clear: a sweep writes every table row invalid, one row per
// cycle. During the sweep beats are still accepted into a 4-entry queue
// but not executed.
// Stall: the response is held in an output register until taken; the
// queue keeps accepting beats while the response waits.
`default_nettype none
module group_by_aggregator #(
	parameter int NUM_GROUPS = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	gba_req_if.sink   req,
	gba_rsp_if.source rsp
);
	import gba_pkg::*;

	localparam int AW = $clog2(NUM_GROUPS);

	logic             head_valid;
	logic [1:0]       head_op;
	logic [AW-1:0]    head_addr;
	logic [VAL_W-1:0] head_value;
	logic             pop;
	back_stat_t       stat;

	gba_front #(
		.NUM_GROUPS (NUM_GROUPS),
		.AW         (AW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.head_valid (head_valid),
		.head_op    (head_op),
		.head_addr  (head_addr),
		.head_value (head_value),
		.pop        (pop)
	);

	gba_back #(
		.NUM_GROUPS (NUM_GROUPS),
		.AW         (AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.head_addr  (head_addr),
		.head_value (head_value),
		.pop        (pop),
		.rsp        (rsp),
		.stat       (stat)
	);

	a_clear_empty_s1: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !stat.s1_v)
		else $error("item in s1 during clear sweep");

	a_no_issue_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !pop)
		else $error("issue during clear sweep");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.group_count == '0 && rsp.group_sum == '0 &&
		rsp.group_min == '0 && rsp.group_max == '0 && rsp.group_avg == '0))
		else $error("absent group with nonzero fields");

	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.found) |-> rsp.group_count != '0)
		else $error("present group with zero count");
endmodule
`default_nettype wire

/* rtl/core/gba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

/* rtl/core/gba_div.sv */
// Bit-serial divider for the group average, one quotient bit a cycle.
// Depends on gba_pkg (entry_t, result_t).
`default_nettype none
module gba_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire gba_pkg::entry_t  ent,
	input  wire logic             ack,
	output logic                  busy,
	output logic                  done,
	output gba_pkg::result_t      res
);
	import gba_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	entry_t            ent_q;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_sub;
	logic              ge;

	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			// an absent group needs no division
			done_q <= !ent.vld;
			cnt_q  <= DIV_CW'(DVD_W);
		end else if (done_q) begin
			if (ack) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CW'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ent_q <= ent;
			den_q <= ent.cnt;
			dvd_q <= {ent.sum, FRAC_W'(0)};
			rem_q <= '0;
		end else if (busy_q && !done_q) begin
			// remainder stays below the divisor, so it fits the count width
			rem_q <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	always_comb begin
		res = '0;
		if (ent_q.vld) begin
			res.found = 1'b1;
			res.count = ent_q.cnt;
			res.sum   = ent_q.sum;
			res.mn    = ent_q.mn;
			res.mx    = ent_q.mx;
			// integer part above 32 bits saturates the Q32.16 average
			res.avg   = (|dvd_q[DVD_W-1:AVG_W]) ? {AVG_W{1'b1}} : dvd_q[AVG_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
endmodule
`default_nettype wire

/* rtl/core/gba_front.sv */
// Front end: accepts request beats, classifies them and queues those it keeps.
// Depends on gba_pkg and gba_if.
`default_nettype none
module gba_front #(
	parameter int NUM_GROUPS = 1024,
	parameter int AW         = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	gba_req_if.sink                  req,
	output logic                     head_valid,
	output logic [1:0]               head_op,
	output logic [AW-1:0]            head_addr,
	output logic [gba_pkg::VAL_W-1:0] head_value,
	input  wire logic                pop
);
	import gba_pkg::*;

	logic [1:0]       op_q   [QDEPTH];
	logic [AW-1:0]    addr_q [QDEPTH];
	logic [VAL_W-1:0] val_q  [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              in_range;
	logic              keep;
	logic [1:0]        op_in;
	logic              push;

	assign in_range = 32'(req.grp_key) < NUM_GROUPS;

	always_comb begin
		keep  = 1'b1;
		op_in = OP_ACC;
		unique case (req.req_type)
			REQ_ACC: begin
				op_in = OP_ACC;
				keep  = in_range;
			end
			REQ_READ: begin
				op_in = in_range ? OP_READ : OP_MISS;
			end
			REQ_CLEAR: begin
				op_in = OP_CLEAR;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign req.ready = cnt_q != QCNT_W'(QDEPTH);
	assign push      = req.valid && req.ready && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]   <= op_in;
			addr_q[wr_ptr_q] <= AW'(req.grp_key);
			val_q[wr_ptr_q]  <= req.value;
		end
	end

	assign head_valid = cnt_q != '0;
	assign head_op    = op_q[rd_ptr_q];
	assign head_addr  = addr_q[rd_ptr_q];
	assign head_value = val_q[rd_ptr_q];
endmodule
`default_nettype wire

/* rtl/core/gba_back.sv */
// Back end: group table, read-modify-write update, clear sweep, response.
// Depends on gba_pkg, gba_if, gba_ram and gba_div.
`default_nettype none
module gba_back #(
	parameter int NUM_GROUPS = 1024,
	parameter int AW         = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 head_valid,
	input  wire logic [1:0]           head_op,
	input  wire logic [AW-1:0]        head_addr,
	input  wire logic [gba_pkg::VAL_W-1:0] head_value,
	output logic                      pop,
	gba_rsp_if.source                 rsp,
	output gba_pkg::back_stat_t       stat
);
	import gba_pkg::*;

	logic             v_s1;
	logic [1:0]       op_s1;
	logic [AW-1:0]    addr_s1;
	logic [VAL_W-1:0] val_s1;
	logic             clr_q;
	logic [AW-1:0]    clr_cnt_q;
	logic             fwd_v_q;
	logic [AW-1:0]    fwd_addr_q;
	entry_t           fwd_data_q;
	logic             out_v_q;
	result_t          out_q;

	logic             s1_done;
	logic             slot_free;
	logic             acc_wr;
	logic [ENTRY_W-1:0] rd_raw;
	entry_t           ram_ent;
	entry_t           ent;
	entry_t           upd;
	logic [SUM_W:0]   sum_ext;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	entry_t           ram_wdata;
	logic             div_start;
	logic             div_busy;
	logic             div_done;
	result_t          div_res;
	logic             load_div;
	logic             load_miss;

	assign slot_free = !out_v_q || rsp.ready;

	always_comb begin
		s1_done = 1'b0;
		if (v_s1) begin
			unique case (op_s1)
				OP_ACC:   s1_done = 1'b1;
				OP_READ:  s1_done = !div_busy;
				OP_MISS:  s1_done = !div_busy && slot_free;
				OP_CLEAR: s1_done = 1'b1;
				default:  s1_done = 1'b0;
			endcase
		end
	end

	// hold issue while a clear waits in s1 or sweeps the table
	assign pop = head_valid && !clr_q &&
		(!v_s1 || (s1_done && op_s1 != OP_CLEAR));

	assign ram_ent = entry_t'(rd_raw);
	assign ent     = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_data_q : ram_ent;
	assign acc_wr  = v_s1 && op_s1 == OP_ACC;
	assign sum_ext = {1'b0, ent.sum} + (SUM_W + 1)'(val_s1);

	always_comb begin
		upd = ent;
		if (!ent.vld) begin
			upd.vld = 1'b1;
			upd.cnt = CNT_W'(1);
			upd.sum = SUM_W'(val_s1);
			upd.mn  = val_s1;
			upd.mx  = val_s1;
		end else begin
			if (ent.cnt != {CNT_W{1'b1}}) begin
				upd.cnt = ent.cnt + 1'b1;
			end
			upd.sum = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
			if (val_s1 < ent.mn) begin
				upd.mn = val_s1;
			end
			if (val_s1 > ent.mx) begin
				upd.mx = val_s1;
			end
		end
	end

	always_comb begin
		ram_we    = acc_wr;
		ram_waddr = addr_s1;
		ram_wdata = upd;
		if (clr_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end
	end

	gba_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_GROUPS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (pop),
		.rd_addr (head_addr),
		.rd_data (rd_raw)
	);

	assign div_start = v_s1 && op_s1 == OP_READ && !div_busy;
	assign load_div  = div_done && slot_free;
	assign load_miss = v_s1 && op_s1 == OP_MISS && s1_done;

	gba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.ent    (ent),
		.ack    (load_div),
		.busy   (div_busy),
		.done   (div_done),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			fwd_v_q   <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (s1_done) begin
				v_s1 <= 1'b0;
			end
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == AW'(NUM_GROUPS - 1)) begin
					clr_q <= 1'b0;
				end
			end else if (v_s1 && op_s1 == OP_CLEAR) begin
				clr_q     <= 1'b1;
				clr_cnt_q <= '0;
			end
			// forward only a write that lands in the cycle the next read issues
			if (pop) begin
				fwd_v_q <= acc_wr;
			end
			if (load_div || load_miss) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1      <= head_op;
			addr_s1    <= head_addr;
			val_s1     <= head_value;
			fwd_addr_q <= addr_s1;
			fwd_data_q <= upd;
		end
		if (load_div) begin
			out_q <= div_res;
		end else if (load_miss) begin
			out_q <= '0;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.found       = out_q.found;
	assign rsp.group_count = out_q.count;
	assign rsp.group_sum   = out_q.sum;
	assign rsp.group_min   = out_q.mn;
	assign rsp.group_max   = out_q.mx;
	assign rsp.group_avg   = out_q.avg;

	assign stat.clearing = clr_q;
	assign stat.s1_v     = v_s1;
	assign stat.div_busy = div_busy;
endmodule
`default_nettype wire
